/* hdl/tvdp_pkg.sv */
// Package for the tile video display processor: item codes, queue entry and FSM state types.
// No dependencies.
package tvdp_pkg;

    localparam logic [2:0] FUNC_CTRL  = 3'd0;
    localparam logic [2:0] FUNC_DATA  = 3'd1;
    localparam logic [2:0] FUNC_PIXEL = 3'd2;
    localparam logic [2:0] FUNC_CRAM  = 3'd3;
    localparam logic [2:0] FUNC_REG   = 3'd4;

    localparam logic [1:0] CODE_REG  = 2'd2;
    localparam logic [1:0] CODE_CRAM = 2'd3;

    localparam logic [7:0] SPR_END = 8'hD0;
    localparam logic [8:0] VROWS   = 9'd224;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] byte_in;
        logic [4:0] read_index;
        logic [7:0] screen_x;
        logic [7:0] screen_y;
    } t_item;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLEAR, ST_CMD, ST_NAME0, ST_NAME1, ST_BGP0, ST_BGP1, ST_BGP2,
        ST_BGP3, ST_BGDONE, ST_SY, ST_SYCHK, ST_SX, ST_SXCHK, ST_SIDX, ST_SIDXW,
        ST_SP0, ST_SP1, ST_SP2, ST_SP3, ST_SPDONE, ST_OUT
    } t_state;

endpackage

/* hdl/tvdp_front.sv */
// Input stage of the tile video display processor: a short word queue toward the engine.
// Depends on tvdp_pkg.
module tvdp_front
    import tvdp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    t_item       r_q [4];
    logic [2:0]  r_cnt;
    logic [1:0]  r_rd, r_wr;
    logic        push, pop;

    assign o_ready = (r_cnt != 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= i_item;
        if (!i_rst_n) begin
            r_cnt <= '0; r_rd <= '0; r_wr <= '0;
        end else begin
            if (push) r_wr <= r_wr + 2'd1;
            if (pop)  r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + {2'd0, push} - {2'd0, pop};
        end
    end
endmodule

/* hdl/tvdp_engine.sv */
// Execution engine: register file, colour RAM, video RAM and the per-pixel sequencer.
// Depends on tvdp_pkg.
module tvdp_engine
    import tvdp_pkg::*;
#(
    parameter int SPRITE_SLOTS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_item      i_item,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [4:0] o_pixel,
    output logic [7:0] o_value
);
    localparam int SW = $clog2(SPRITE_SLOTS + 1);

    logic [7:0]  r_vram [16384];
    logic [7:0]  r_cram [32];
    logic [7:0]  r_regs [16];
    logic [13:0] r_addr;
    logic [1:0]  r_code;
    logic        r_half;
    logic [7:0]  r_first;

    t_state r_st, n_st;
    t_item  r_it;
    logic [13:0] r_clr;
    logic [13:0] r_ra, n_ra;
    logic [7:0]  r_rdat;
    logic [7:0]  r_b0, r_b1, r_b2;
    logic [15:0] r_ent;
    logic [SW-1:0] r_s;
    logic [7:0]  r_sy, r_sx;
    logic [13:0] r_srow;
    logic [4:0]  r_pix;
    logic [7:0]  r_val;
    logic        r_ov;

    logic        we;
    logic [13:0] wa;
    logic [7:0]  wd;

    // Derived pixel values.
    logic [4:0]  border;
    logic [8:0]  vy;
    logic [7:0]  vx, y9m;
    logic [2:0]  col, ry, sh;
    logic [13:0] ea, sat;
    logic [13:0] bgrow;
    logic [8:0]  sy1, yrel;
    logic [7:0]  xrel;
    logic [7:0]  sidx;
    logic        tall, hit_y;
    logic [3:0]  pcol;

    assign border = 5'd16 + {1'b0, r_regs[7][3:0]};
    assign y9m    = (r_regs[9] >= VROWS[7:0]) ? r_regs[9] - VROWS[7:0] : r_regs[9];
    always_comb begin
        vy = {1'b0, r_it.screen_y} + {1'b0, y9m};
        if (vy >= {VROWS[7:0], 1'b0}) vy = vy - {VROWS[7:0], 1'b0};
        else if (vy >= VROWS) vy = vy - VROWS;
    end
    assign vx   = r_it.screen_x - r_regs[8];
    assign ea   = {r_regs[2][3:1], 11'd0} + {3'd0, vy[7:3], vx[7:3], 1'b0};
    assign col  = r_ent[9]  ? ~vx[2:0] : vx[2:0];
    // At NAME1 the entry high byte is on the read data and the low byte sits in r_b0.
    assign ry   = r_rdat[2] ? ~vy[2:0] : vy[2:0];
    assign bgrow = {r_rdat[0], r_b0, ry, 2'b00};
    assign sat  = {r_regs[5][6:1], 8'd0};
    assign tall = r_regs[1][1];
    assign sy1  = {1'b0, r_sy + 8'd1};
    assign yrel = {1'b0, r_it.screen_y} - sy1;
    assign hit_y = ({1'b0, r_it.screen_y} >= sy1) && (yrel < (tall ? 9'd16 : 9'd8));
    assign xrel = r_it.screen_x - r_sx;
    assign sidx = tall ? {r_rdat[7:1], 1'b0} : r_rdat;
    assign sh   = (r_st == ST_BGP3 || r_st == ST_BGDONE) ? ~col : ~xrel[2:0];
    assign pcol = {r_rdat[sh], r_b2[sh], r_b1[sh], r_b0[sh]};

    assign o_ready = (r_st == ST_IDLE) && !r_ov;
    assign o_valid = r_ov;
    assign o_pixel = r_pix;
    assign o_value = r_val;

    // Next state.
    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_CLEAR:  if (r_clr == 14'h3FFF) n_st = ST_IDLE;
            ST_IDLE:   if (i_valid && !r_ov) n_st = ST_CMD;
            ST_CMD: begin
                if (r_it.func == FUNC_PIXEL && r_regs[1][6] &&
                    !(r_regs[0][5] && r_it.screen_x < 8'd8)) n_st = ST_NAME0;
                else n_st = ST_OUT;
            end
            ST_NAME0:  n_st = ST_NAME1;
            ST_NAME1:  n_st = ST_BGP0;
            ST_BGP0:   n_st = ST_BGP1;
            ST_BGP1:   n_st = ST_BGP2;
            ST_BGP2:   n_st = ST_BGP3;
            ST_BGP3:   n_st = ST_BGDONE;
            ST_BGDONE: n_st = (r_ent[12] && pcol != 4'd0) ? ST_OUT : ST_SY;
            ST_SY:     n_st = (r_s == SW'(SPRITE_SLOTS)) ? ST_OUT : ST_SYCHK;
            ST_SYCHK:  n_st = (r_rdat == SPR_END) ? ST_OUT : ST_SX;
            ST_SX:     n_st = hit_y ? ST_SXCHK : ST_SY;
            ST_SXCHK:  n_st = (r_it.screen_x >= r_rdat &&
                              (r_it.screen_x - r_rdat) < 8'd8) ? ST_SIDX : ST_SY;
            ST_SIDX:   n_st = ST_SIDXW;
            ST_SIDXW:  n_st = ST_SP0;
            ST_SP0:    n_st = ST_SP1;
            ST_SP1:    n_st = ST_SP2;
            ST_SP2:    n_st = ST_SP3;
            ST_SP3:    n_st = ST_SPDONE;
            ST_SPDONE: n_st = (pcol != 4'd0) ? ST_OUT : ST_SY;
            ST_OUT:    n_st = ST_IDLE;
            default:   n_st = ST_IDLE;
        endcase
    end

    // Video RAM read address per state.
    always_comb begin
        n_ra = r_ra;
        case (r_st)
            ST_CMD:    n_ra = ea;
            ST_NAME0:  n_ra = ea + 14'd1;
            ST_NAME1:  n_ra = bgrow;
            ST_BGP0:   n_ra = r_ra + 14'd1;
            ST_BGP1:   n_ra = r_ra + 14'd1;
            ST_BGP2:   n_ra = r_ra + 14'd1;
            ST_SY:     n_ra = sat + 14'(r_s);
            ST_SYCHK:  n_ra = sat + 14'h80 + 14'({r_s - SW'(1), 1'b0});
            ST_SXCHK:  n_ra = r_ra + 14'd1;
            ST_SIDXW:  n_ra = r_srow;
            ST_SP0:    n_ra = r_ra + 14'd1;
            ST_SP1:    n_ra = r_ra + 14'd1;
            ST_SP2:    n_ra = r_ra + 14'd1;
            default:   n_ra = r_ra;
        endcase
    end

    // Store writes.
    always_comb begin
        we = 1'b0; wa = r_addr; wd = r_it.byte_in;
        if (r_st == ST_CLEAR) begin
            we = 1'b1; wa = r_clr; wd = 8'd0;
        end else if (r_st == ST_CMD && r_it.func == FUNC_DATA && r_code != CODE_CRAM) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_vram[wa] <= wd;
        r_rdat <= r_vram[n_ra];
    end

    always_ff @(posedge i_clk) begin
        r_ra <= n_ra;
        if (r_st == ST_IDLE) r_it <= i_item;
        case (r_st)
            ST_NAME0:  r_b0 <= r_rdat;
            ST_NAME1:  r_ent <= {r_rdat, r_b0};
            ST_BGP0:   r_b0 <= r_rdat;
            ST_BGP1:   r_b1 <= r_rdat;
            ST_BGP2:   r_b2 <= r_rdat;
            ST_SP0:    r_b0 <= r_rdat;
            ST_SP1:    r_b1 <= r_rdat;
            ST_SP2:    r_b2 <= r_rdat;
            ST_SYCHK:  r_sy <= r_rdat;
            ST_SXCHK:  r_sx <= r_rdat;
            ST_SIDX:   r_srow <= {r_regs[6][2], 13'd0} +
                           {1'b0, 8'(sidx + {7'd0, yrel[3]}), 5'd0} + {9'd0, yrel[2:0], 2'b00};
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR; r_clr <= '0; r_ov <= 1'b0;
            r_addr <= '0; r_code <= '0; r_half <= 1'b0; r_first <= '0;
            r_s <= '0; r_pix <= '0; r_val <= '0;
            for (int k = 0; k < 16; k++) r_regs[k] <= '0;
            for (int k = 0; k < 32; k++) r_cram[k] <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == ST_CLEAR) r_clr <= r_clr + 14'd1;
            if (o_valid && i_ready) r_ov <= 1'b0;
            if (r_st == ST_CMD) begin
                r_pix <= '0; r_val <= '0; r_s <= '0;
                case (r_it.func)
                    FUNC_CTRL: begin
                        if (!r_half) begin
                            r_first <= r_it.byte_in; r_half <= 1'b1;
                        end else begin
                            r_half <= 1'b0;
                            r_code <= r_it.byte_in[7:6];
                            if (r_it.byte_in[7:6] == CODE_REG)
                                r_regs[r_it.byte_in[3:0]] <= r_first;
                            else
                                r_addr <= {r_it.byte_in[5:0], r_first};
                        end
                    end
                    FUNC_DATA: begin
                        r_half <= 1'b0;
                        if (r_code == CODE_CRAM) r_cram[r_addr[4:0]] <= r_it.byte_in;
                        r_addr <= r_addr + 14'd1;
                    end
                    FUNC_PIXEL: r_pix <= border;
                    FUNC_CRAM:  r_val <= r_cram[r_it.read_index];
                    FUNC_REG:   r_val <= r_regs[r_it.read_index[3:0]];
                    default: ;
                endcase
            end
            if (r_st == ST_BGDONE) r_pix <= {r_ent[11], 4'd0} + {1'b0, pcol};
            if (r_st == ST_SY) r_s <= r_s + SW'(1);
            if (r_st == ST_SPDONE && pcol != 4'd0) r_pix <= {1'b1, pcol};
            if (r_st == ST_OUT) r_ov <= 1'b1;
        end
    end
endmodule

/* hdl/tile_video_display_processor.sv */
// Tile video display processor: front queue plus execution engine.
// Control, data, read and blanked pixel words go straight to the result; a pixel word fetches
// its background name entry and pattern, then scans sprite slots (each dropped on Y, dropped on X
// or fetched) unless a priority background pixel settles it, all through the single video RAM read port.
// One word in service; the next is taken only after the result leaves. Sync active-low reset
// clears control state, then a pass zeroes all 16384 video RAM bytes (engine takes no words).
module tile_video_display_processor
    import tvdp_pkg::*;
#(
    parameter int SPRITE_SLOTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // bits 7:0 byte_in, 12:8 read_index, 20:13 screen_x, 28:21 screen_y, 31:29 zero
    input  logic [31:0] s_axis_tdata,
    // func
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // bits 4:0 pixel_index, 12:5 read_value, 15:13 zero
    output logic [15:0] m_axis_tdata
);
    t_item in_it, q_it;
    logic  q_v, q_r;
    logic [4:0] pix;
    logic [7:0] val;

    assign in_it = '{func: s_axis_tuser, byte_in: s_axis_tdata[7:0],
                     read_index: s_axis_tdata[12:8], screen_x: s_axis_tdata[20:13],
                     screen_y: s_axis_tdata[28:21]};

    tvdp_front u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_item(in_it),
        .o_valid(q_v), .i_ready(q_r), .o_item(q_it)
    );

    tvdp_engine #(.SPRITE_SLOTS(SPRITE_SLOTS)) u_engine (
        .i_clk, .i_rst_n, .i_valid(q_v), .o_ready(q_r), .i_item(q_it),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_pixel(pix), .o_value(val)
    );

    assign m_axis_tdata = {3'd0, val, pix};
endmodule
